/* hw/rtl/mcip_pkg.sv */
// shared types and constants of the masked complex inner product unit
package mcip_pkg;

  localparam int unsigned ACC_BITS     = 48;
  localparam int unsigned CFG_INDEX_W  = 24;
  localparam int unsigned QUBIT_W      = 5;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned OUT_DATA_W   = 2 * ACC_BITS;

  typedef enum logic [1:0] {
    MODE_ALL     = 2'd0,
    MODE_MATCH   = 2'd1,
    MODE_BIT_SET = 2'd2,
    MODE_BIT_CLR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_INDEX_MASK   = 2'd1,
    REG_INDEX_MATCH  = 2'd2,
    REG_TARGET_QUBIT = 2'd3
  } reg_addr_e;

  typedef struct packed {
    mode_e                  mode;
    logic [CFG_INDEX_W-1:0] index_mask;
    logic [CFG_INDEX_W-1:0] index_match;
    logic [QUBIT_W-1:0]     target_qubit;
  } cfg_t;

  typedef struct packed {
    logic counted;
    logic last;
  } item_ctl_t;

  localparam int unsigned CTL_W = $bits(item_ctl_t);

endpackage

/* hw/rtl/mcip_regs.sv */
// apb configuration registers
module mcip_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcip_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mcip_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mcip_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output mcip_pkg::cfg_t                     cfg_o
);

  mcip_pkg::cfg_t      cfg_q, cfg_d;
  mcip_pkg::reg_addr_e addr;
  logic                wr_en;

  assign pready = 1'b1;
  assign addr   = mcip_pkg::reg_addr_e'(paddr[mcip_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (addr)
        mcip_pkg::REG_MODE:
          cfg_d.mode = mcip_pkg::mode_e'(pwdata[1:0]);
        mcip_pkg::REG_INDEX_MASK:
          cfg_d.index_mask = pwdata[mcip_pkg::CFG_INDEX_W-1:0];
        mcip_pkg::REG_INDEX_MATCH:
          cfg_d.index_match = pwdata[mcip_pkg::CFG_INDEX_W-1:0];
        mcip_pkg::REG_TARGET_QUBIT:
          cfg_d.target_qubit = pwdata[mcip_pkg::QUBIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (addr)
      mcip_pkg::REG_MODE:         prdata = mcip_pkg::APB_DATA_W'(cfg_q.mode);
      mcip_pkg::REG_INDEX_MASK:   prdata = mcip_pkg::APB_DATA_W'(cfg_q.index_mask);
      mcip_pkg::REG_INDEX_MATCH:  prdata = mcip_pkg::APB_DATA_W'(cfg_q.index_match);
      mcip_pkg::REG_TARGET_QUBIT: prdata = mcip_pkg::APB_DATA_W'(cfg_q.target_qubit);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: mcip_pkg::MODE_ALL, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/mcip_front.sv */
// front end: element index tracking and element selection
module mcip_front #(
  parameter int unsigned INDEX_BITS = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mcip_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  input  logic [4*SAMPLE_BITS-1:0] in_samples_i,
  input  logic                     in_last_i,
  output logic                     in_ready_o,
  output logic                     push_o,
  output logic [4*SAMPLE_BITS-1:0] push_samples_o,
  output mcip_pkg::item_ctl_t      push_ctl_o,
  input  logic                     queue_ready_i
);

  localparam int unsigned CMP_W =
    (INDEX_BITS > mcip_pkg::CFG_INDEX_W) ? INDEX_BITS : mcip_pkg::CFG_INDEX_W;

  logic [INDEX_BITS-1:0] index_q, index_d;
  logic [INDEX_BITS-1:0] index_shifted;
  logic [CMP_W-1:0]      index_masked;
  logic                  qubit_bit;
  logic                  counted;

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i & queue_ready_i;

  // bit past the index width reads as zero, which the shift gives for free
  assign index_shifted = index_q >> cfg_i.target_qubit;
  assign qubit_bit     = index_shifted[0];
  assign index_masked  = CMP_W'(index_q) & CMP_W'(cfg_i.index_mask);

  always_comb begin
    case (cfg_i.mode)
      mcip_pkg::MODE_ALL:     counted = 1'b1;
      mcip_pkg::MODE_MATCH:   counted = (index_masked == CMP_W'(cfg_i.index_match));
      mcip_pkg::MODE_BIT_SET: counted = qubit_bit;
      mcip_pkg::MODE_BIT_CLR: counted = ~qubit_bit;
      default:                counted = 1'b1;
    endcase
  end

  assign push_samples_o     = in_samples_i;
  assign push_ctl_o.counted = counted;
  assign push_ctl_o.last    = in_last_i;

  always_comb begin
    index_d = index_q;
    if (push_o) begin
      index_d = in_last_i ? '0 : index_q + INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
    end else begin
      index_q <= index_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && in_last_i |=> index_q == '0)
    else $error("element index not restarted after last transfer");
  a_all_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cfg_i.mode == mcip_pkg::MODE_ALL |-> push_ctl_o.counted)
    else $error("element dropped while every element should count");
`endif

endmodule

/* hw/rtl/mcip_queue.sv */
// short queue between front end and arithmetic back end
module mcip_queue #(
  parameter int unsigned WIDTH = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int unsigned DEPTH = mcip_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count past depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !ready_o |=> count_q == $past(count_q) - CNT_W'($past(do_pop)))
    else $error("queue took a transfer while full");
`endif

endmodule

/* hw/rtl/mcip_back.sv */
// back end: complex multiply, saturating accumulate and result register
module mcip_back #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             head_valid_i,
  input  logic [4*SAMPLE_BITS-1:0]         head_samples_i,
  input  mcip_pkg::item_ctl_t              head_ctl_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  output logic [mcip_pkg::OUT_DATA_W-1:0]  out_data_o,
  input  logic                             out_ready_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned PW    = 2 * SB;
  localparam int unsigned TW    = PW + 1;
  localparam int unsigned AB    = mcip_pkg::ACC_BITS;
  localparam int unsigned SUM_W = ((TW + 1 > AB) ? TW + 1 : AB) + 1;

  logic signed [SB-1:0] bra_re, bra_im, ket_re, ket_im;

  // stage 1: four products
  logic                s1_valid_q;
  mcip_pkg::item_ctl_t s1_ctl_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  // stage 2: per-element terms
  logic                s2_valid_q;
  logic                s2_last_q;
  logic signed [TW-1:0] t_re_q, t_im_q;

  // accumulators and result register
  logic signed [AB-1:0]    acc_re_q, acc_im_q;
  logic signed [AB-1:0]    sat_re, sat_im;
  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic                    out_valid_q;
  logic [AB-1:0]           dot_re_q, dot_im_q;
  logic                    advance, load;

  function automatic logic signed [AB-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-AB:0] upper;
    upper = v[SUM_W-1:AB-1];
    if (upper == '0 || upper == '1) begin
      sat_acc = v[AB-1:0];
    end else if (v[SUM_W-1]) begin
      sat_acc = {1'b1, {(AB-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(AB-1){1'b1}}};
    end
  endfunction

  assign bra_re = $signed(head_samples_i[SB-1:0]);
  assign bra_im = $signed(head_samples_i[2*SB-1:SB]);
  assign ket_re = $signed(head_samples_i[3*SB-1:2*SB]);
  assign ket_im = $signed(head_samples_i[4*SB-1:3*SB]);

  // pipe holds only while a finished sum cannot enter the result register
  assign advance = ~(s2_valid_q & s2_last_q & out_valid_q & ~out_ready_i);
  assign pop_o   = advance & head_valid_i;
  assign load    = advance & s2_valid_q & s2_last_q;

  assign sum_re = SUM_W'(acc_re_q) + SUM_W'(t_re_q);
  assign sum_im = SUM_W'(acc_im_q) + SUM_W'(t_im_q);
  assign sat_re = sat_acc(sum_re);
  assign sat_im = sat_acc(sum_im);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_ctl_q  <= head_ctl_i;
      p_rr_q    <= bra_re * ket_re;
      p_ii_q    <= bra_im * ket_im;
      p_ri_q    <= bra_re * ket_im;
      p_ir_q    <= bra_im * ket_re;
      s2_last_q <= s1_ctl_q.last;
      t_re_q    <= s1_ctl_q.counted ? TW'(p_rr_q) + TW'(p_ii_q) : '0;
      t_im_q    <= s1_ctl_q.counted ? TW'(p_ri_q) - TW'(p_ir_q) : '0;
    end
    if (load) begin
      dot_re_q <= sat_re;
      dot_im_q <= sat_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_q <= head_valid_i;
        s2_valid_q <= s1_valid_q;
        if (s2_valid_q) begin
          acc_re_q <= s2_last_q ? '0 : sat_re;
          acc_im_q <= s2_last_q ? '0 : sat_im;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {dot_im_q, dot_re_q};

`ifndef NO_ASSERTIONS
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> acc_re_q == '0 && acc_im_q == '0)
    else $error("accumulators not cleared after result load");
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten before transfer");
`endif

endmodule

/* hw/rtl/masked_complex_inner_product_unit.sv */
// top level of the masked complex inner product unit
//
// input stream: one element per transfer, tdata carries bra_re, bra_im, ket_re and
// ket_im (signed q1.15 at the default sample width), tlast marks the last element
// of a vector. the element index starts at zero and counts up per transfer.
// apb registers select which elements count: all, masked index match, target
// qubit bit set, or that bit clear. write them only while the unit is idle.
// output stream: one transfer per vector, tdata carries dot_re and dot_im, each
// the saturated q18.30 sum of conj(bra)*ket over the counted elements.
// throughput: one element per cycle while the result register can take finished
// sums, set by the four multipliers in the back end and the accumulate.
// the result shows on m_axis_tvalid once the transfer that carries tlast has
// passed the queue, product stage, term stage and result register.
// reset clears the registers, element index, accumulators and queue.
// when the receiver stalls, the result waits in the output register; elements
// keep flowing until another finished vector needs that register, then the
// two-entry queue fills and s_axis_tready drops.
module masked_complex_inner_product_unit #(
  parameter int unsigned INDEX_BITS  = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // bra_re, bra_im, ket_re, ket_im from lowest bit up, zero padded to bytes
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // master stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // dot_re, dot_im from lowest bit up
  output logic [mcip_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcip_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mcip_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mcip_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int unsigned SAMP_W  = 4 * SAMPLE_BITS;
  localparam int unsigned ENTRY_W = SAMP_W + mcip_pkg::CTL_W;

  mcip_pkg::cfg_t      cfg;
  logic                push, queue_ready;
  logic [SAMP_W-1:0]   push_samples;
  mcip_pkg::item_ctl_t push_ctl;
  logic                head_valid, pop;
  logic [ENTRY_W-1:0]  head;
  mcip_pkg::item_ctl_t head_ctl;

  // register file
  mcip_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front end tags each element as counted or not
  mcip_front #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_samples_i   (s_axis_tdata[SAMP_W-1:0]),
    .in_last_i      (s_axis_tlast),
    .in_ready_o     (s_axis_tready),
    .push_o         (push),
    .push_samples_o (push_samples),
    .push_ctl_o     (push_ctl),
    .queue_ready_i  (queue_ready)
  );

  // queue decouples tagging from arithmetic
  mcip_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctl, push_samples}),
    .ready_o     (queue_ready),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  assign head_ctl = mcip_pkg::item_ctl_t'(head[ENTRY_W-1:SAMP_W]);

  // multiply, accumulate and hold the result for the master stream
  mcip_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_samples_i (head[SAMP_W-1:0]),
    .head_ctl_i     (head_ctl),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_data_o     (m_axis_tdata),
    .out_ready_i    (m_axis_tready)
  );

endmodule
